FILE: rtl/fir_pkg.sv
// ---------------------------------------------------------------------------
// fir_pkg
// Shared widths, codes and control bundles for the FIR convolution block.
// ---------------------------------------------------------------------------
`default_nettype none

package fir_pkg;

  // Defaults for the top-level parameters
  localparam int MAX_TAPS_DEF     = 64;
  localparam int SAMPLE_WIDTH_DEF = 16;

  // Fixed field widths
  localparam int ACC_W       = 48;
  localparam int TAP_COUNT_W = 7;
  localparam int TAP_INDEX_W = 6;

  // Configuration port
  localparam int PADDR_W   = 3;
  localparam int PDATA_W   = 32;
  localparam int CFG_IDX_W = 1;
  localparam logic [CFG_IDX_W-1:0] REG_TAP_COUNT = 1'b0;
  localparam logic [TAP_COUNT_W-1:0] TAP_COUNT_RST = 7'd1;

  // Input operation codes
  localparam logic OP_LOAD   = 1'b0;
  localparam logic OP_SAMPLE = 1'b1;

  // Delay cell control
  typedef struct packed {
    logic shift;   // take the left neighbour, new sample at the head
    logic rotate;  // take the right neighbour, ring walk
    logic clear;   // zero the cell
  } cell_ctrl_t;

  // Multiply-accumulate control
  typedef struct packed {
    logic clear;   // start of a new output
    logic en;      // coefficient/sample pair is in use
  } mac_ctrl_t;

endpackage : fir_pkg

`default_nettype wire

FILE: rtl/fir_in_if.sv
// ---------------------------------------------------------------------------
// fir_in_if
// Input channel: tap loads and samples, valid/ready handshake.
// ---------------------------------------------------------------------------
`default_nettype none

interface fir_in_if #(
  parameter int SAMPLE_WIDTH = fir_pkg::SAMPLE_WIDTH_DEF
) ();
  logic                               valid;
  logic                               ready;
  logic                               operation;
  logic [fir_pkg::TAP_INDEX_W-1:0]    tap_index;
  logic signed [SAMPLE_WIDTH-1:0]     value;
  logic                               last;

  modport source (output valid, operation, tap_index, value, last, input ready);
  modport sink   (input valid, operation, tap_index, value, last, output ready);
endinterface : fir_in_if

`default_nettype wire

FILE: rtl/fir_out_if.sv
// ---------------------------------------------------------------------------
// fir_out_if
// Output channel: one convolution output per beat, valid/ready handshake.
// ---------------------------------------------------------------------------
`default_nettype none

interface fir_out_if #(
  parameter int SAMPLE_WIDTH = fir_pkg::SAMPLE_WIDTH_DEF
) ();
  logic                           valid;
  logic                           ready;
  logic signed [SAMPLE_WIDTH-1:0] sample;
  logic                           saturated;
  logic                           last_res;

  modport source (output valid, sample, saturated, last_res, input ready);
  modport sink   (input valid, sample, saturated, last_res, output ready);
endinterface : fir_out_if

`default_nettype wire

FILE: rtl/fir_cell.sv
// ---------------------------------------------------------------------------
// fir_cell
// One delay-line cell: shifts in from the left, rotates in from the right.
// ---------------------------------------------------------------------------
`default_nettype none

module fir_cell #(
  parameter int SAMPLE_WIDTH = fir_pkg::SAMPLE_WIDTH_DEF
) (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire fir_pkg::cell_ctrl_t            ctrl,
  input  wire logic signed [SAMPLE_WIDTH-1:0] left_in,
  input  wire logic signed [SAMPLE_WIDTH-1:0] right_in,
  output logic signed [SAMPLE_WIDTH-1:0]      q
);
  import fir_pkg::*;

  // Delay-line starts empty and is emptied after each tail
  always_ff @(posedge clk) begin
    if (rst || ctrl.clear) begin
      q <= '0;
    end else if (ctrl.shift) begin
      q <= left_in;
    end else if (ctrl.rotate) begin
      q <= right_in;
    end
  end

endmodule : fir_cell

`default_nettype wire

FILE: rtl/fir_mac.sv
// ---------------------------------------------------------------------------
// fir_mac
// Shared multiply-accumulate with round-half-up, shift and saturation.
// ---------------------------------------------------------------------------
`default_nettype none

module fir_mac #(
  parameter int SAMPLE_WIDTH = fir_pkg::SAMPLE_WIDTH_DEF
) (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire fir_pkg::mac_ctrl_t             ctrl,
  input  wire logic signed [SAMPLE_WIDTH-1:0] coef,
  input  wire logic signed [SAMPLE_WIDTH-1:0] samp,
  output logic signed [SAMPLE_WIDTH-1:0]      res_sample,
  output logic                                res_sat
);
  import fir_pkg::*;

  localparam int FRAC = SAMPLE_WIDTH - 1;
  localparam int PW   = 2 * SAMPLE_WIDTH;
  localparam int VW   = ACC_W + 1;

  localparam logic signed [VW-1:0] ROUND_C = VW'(1) <<< (FRAC - 1);
  localparam logic signed [VW-1:0] HI_C    = (VW'(1) <<< FRAC) - VW'(1);
  localparam logic signed [VW-1:0] LO_C    = -HI_C - VW'(1);

  logic signed [PW-1:0]    prod;
  logic                    prod_en;
  logic signed [ACC_W-1:0] acc;
  logic signed [VW-1:0]    rounded;
  logic signed [VW-1:0]    shifted;

  // Product register, then accumulate modulo 2^48
  always_ff @(posedge clk) begin
    prod <= coef * samp;
    if (rst) begin
      prod_en <= 1'b0;
    end else begin
      prod_en <= ctrl.en;
    end
    if (rst || ctrl.clear) begin
      acc <= '0;
    end else if (prod_en) begin
      acc <= acc + ACC_W'(prod);
    end
  end

  // Round half up, floor shift, clip to the sample range
  always_comb begin
    rounded = VW'(acc) + ROUND_C;
    shifted = rounded >>> FRAC;
    if (shifted > HI_C) begin
      res_sample = HI_C[SAMPLE_WIDTH-1:0];
      res_sat    = 1'b1;
    end else if (shifted < LO_C) begin
      res_sample = LO_C[SAMPLE_WIDTH-1:0];
      res_sat    = 1'b1;
    end else begin
      res_sample = shifted[SAMPLE_WIDTH-1:0];
      res_sat    = 1'b0;
    end
  end

endmodule : fir_mac

`default_nettype wire

FILE: rtl/fir_full_convolution.sv
// ---------------------------------------------------------------------------
// fir_full_convolution
// Full linear convolution of a sample stream with a loaded impulse response.
// ---------------------------------------------------------------------------
// The delay line is a ring of MAX_TAPS cells. For a sample, its beat shifts
// it in, the ring then walks once past the single multiply-accumulate unit
// (coefficients come from a MAX_TAPS-entry memory, one read a cycle), the
// multiplier and accumulator pipeline drains, and the output register is
// loaded. A sample marked last is followed by n_use - 1 tail outputs, one
// fewer than the taps in use, after which the delay line is zeroed. The
// input is taken only when the block is idle; a finished result waits in
// the output register without holding up the next input beat.
`default_nettype none

module fir_full_convolution #(
  parameter int MAX_TAPS     = fir_pkg::MAX_TAPS_DEF,
  parameter int SAMPLE_WIDTH = fir_pkg::SAMPLE_WIDTH_DEF
) (
  input  wire logic                            clk,
  input  wire logic                            rst,
  fir_in_if.sink                               in_ch,
  fir_out_if.source                            out_ch,
  input  wire logic                            psel,
  input  wire logic                            penable,
  input  wire logic                            pwrite,
  input  wire logic [fir_pkg::PADDR_W-1:0]     paddr,
  input  wire logic [fir_pkg::PDATA_W-1:0]     pwdata,
  output logic [fir_pkg::PDATA_W-1:0]          prdata,
  output logic                                 pready
);
  import fir_pkg::*;

  localparam int IDX_W = (MAX_TAPS > 1) ? $clog2(MAX_TAPS) : 1;
  localparam logic [IDX_W-1:0]       LAST_STEP = IDX_W'(MAX_TAPS - 1);
  localparam logic [TAP_COUNT_W-1:0] MAX_N     = TAP_COUNT_W'(MAX_TAPS);

  typedef enum logic [1:0] {S_IDLE, S_RUN, S_DRAIN, S_OUT} state_t;

  state_t                    state;
  logic [IDX_W-1:0]          step;
  logic                      drain;
  logic [TAP_COUNT_W-1:0]    n_taps;
  logic [TAP_COUNT_W-1:0]    flush_left;
  logic                      last_sig;
  logic [TAP_COUNT_W-1:0]    tap_count;
  logic [TAP_COUNT_W-1:0]    n_use;

  logic                      in_beat;
  logic                      smp_beat;
  logic                      out_load;
  logic                      cfg_wr;

  logic signed [SAMPLE_WIDTH-1:0] coef_mem [MAX_TAPS];
  logic [MAX_TAPS-1:0]            coef_vld;
  logic signed [SAMPLE_WIDTH-1:0] coef_rd;
  logic                           coef_ok;
  logic [IDX_W-1:0]               coef_addr;
  logic [TAP_COUNT_W-1:0]         addr_full;

  logic signed [SAMPLE_WIDTH-1:0] tap_q [MAX_TAPS];
  logic signed [SAMPLE_WIDTH-1:0] head_d;
  logic signed [SAMPLE_WIDTH-1:0] shift_val;
  logic                           pair_en;
  cell_ctrl_t                     cell_ctrl;
  mac_ctrl_t                      mac_ctrl;
  logic signed [SAMPLE_WIDTH-1:0] res_sample;
  logic                           res_sat;

  logic                           out_valid;
  logic signed [SAMPLE_WIDTH-1:0] out_sample;
  logic                           out_sat;
  logic                           out_last;

  // Configuration register
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      tap_count <= TAP_COUNT_RST;
    end else if (cfg_wr && paddr[PADDR_W-1 -: CFG_IDX_W] == REG_TAP_COUNT) begin
      tap_count <= pwdata[TAP_COUNT_W-1:0];
    end
  end

  always_comb begin
    if (paddr[PADDR_W-1 -: CFG_IDX_W] == REG_TAP_COUNT) begin
      prdata = PDATA_W'(tap_count);
    end else begin
      prdata = '0;
    end
  end

  // Taps in use: zero counts as one, clipped to the ring length
  always_comb begin
    if (tap_count == '0) begin
      n_use = TAP_COUNT_W'(1);
    end else if (tap_count > MAX_N) begin
      n_use = MAX_N;
    end else begin
      n_use = tap_count;
    end
  end

  // Handshakes
  assign in_ch.ready = (state == S_IDLE);
  assign in_beat     = in_ch.valid && in_ch.ready;
  assign smp_beat    = in_beat && (in_ch.operation == OP_SAMPLE);
  assign out_load    = (state == S_OUT) && (!out_valid || out_ch.ready);

  // Coefficient memory; unwritten slots read as zero
  assign addr_full = n_taps - TAP_COUNT_W'(1) - TAP_COUNT_W'(step);
  assign coef_addr = addr_full[IDX_W-1:0];

  always_ff @(posedge clk) begin
    if (in_beat && in_ch.operation == OP_LOAD
        && TAP_COUNT_W'(in_ch.tap_index) < MAX_N) begin
      coef_mem[in_ch.tap_index[IDX_W-1:0]] <= in_ch.value;
    end
    coef_rd <= coef_mem[coef_addr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      coef_vld <= '0;
      coef_ok  <= 1'b0;
    end else begin
      if (in_beat && in_ch.operation == OP_LOAD
          && TAP_COUNT_W'(in_ch.tap_index) < MAX_N) begin
        coef_vld[in_ch.tap_index[IDX_W-1:0]] <= 1'b1;
      end
      coef_ok <= coef_vld[coef_addr];
    end
  end

  // Delay-line ring control
  always_comb begin
    cell_ctrl.shift  = smp_beat || (out_load && flush_left != '0);
    cell_ctrl.rotate = (state == S_RUN);
    cell_ctrl.clear  = out_load && flush_left == '0 && last_sig;
    shift_val        = smp_beat ? in_ch.value : '0;
  end

  for (genvar k = 0; k < MAX_TAPS; k++) begin : g_cell
    logic signed [SAMPLE_WIDTH-1:0] left_d;
    if (k == 0) begin : g_head
      assign left_d = shift_val;
    end else begin : g_body
      assign left_d = tap_q[k-1];
    end
    fir_cell #(
      .SAMPLE_WIDTH (SAMPLE_WIDTH)
    ) u_cell (
      .clk      (clk),
      .rst      (rst),
      .ctrl     (cell_ctrl),
      .left_in  (left_d),
      .right_in (tap_q[(k + 1) % MAX_TAPS]),
      .q        (tap_q[k])
    );
  end

  // Head sample and pair flag line up with the coefficient read
  always_ff @(posedge clk) begin
    head_d <= tap_q[0];
    if (rst) begin
      pair_en <= 1'b0;
    end else begin
      pair_en <= (state == S_RUN) && (TAP_COUNT_W'(step) < n_taps);
    end
  end

  always_comb begin
    mac_ctrl.clear = cell_ctrl.shift;
    mac_ctrl.en    = pair_en;
  end

  fir_mac #(
    .SAMPLE_WIDTH (SAMPLE_WIDTH)
  ) u_mac (
    .clk        (clk),
    .rst        (rst),
    .ctrl       (mac_ctrl),
    .coef       (coef_ok ? coef_rd : '0),
    .samp       (head_d),
    .res_sample (res_sample),
    .res_sat    (res_sat)
  );

  // Sequencer and output register
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      step       <= '0;
      drain      <= 1'b0;
      n_taps     <= TAP_COUNT_W'(1);
      flush_left <= '0;
      last_sig   <= 1'b0;
      out_valid  <= 1'b0;
    end else begin
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (smp_beat) begin
            n_taps     <= n_use;
            flush_left <= in_ch.last ? (n_use - TAP_COUNT_W'(1)) : '0;
            last_sig   <= in_ch.last;
            step       <= '0;
            state      <= S_RUN;
          end
        end
        S_RUN: begin
          if (step == LAST_STEP) begin
            step  <= '0;
            drain <= 1'b0;
            state <= S_DRAIN;
          end else begin
            step <= step + IDX_W'(1);
          end
        end
        S_DRAIN: begin
          drain <= 1'b1;
          if (drain) begin
            state <= S_OUT;
          end
        end
        S_OUT: begin
          if (out_load) begin
            out_sample <= res_sample;
            out_sat    <= res_sat;
            out_last   <= last_sig && flush_left == '0;
            if (flush_left != '0) begin
              flush_left <= flush_left - TAP_COUNT_W'(1);
              state      <= S_RUN;
            end else begin
              last_sig <= 1'b0;
              state    <= S_IDLE;
            end
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  assign out_ch.valid     = out_valid;
  assign out_ch.sample    = out_sample;
  assign out_ch.saturated = out_sat;
  assign out_ch.last_res  = out_last;

endmodule : fir_full_convolution

`default_nettype wire

FILE: rtl/fir_chk.sv
// ---------------------------------------------------------------------------
// fir_chk
// Port-level checks for the FIR convolution block, bound to the top level.
// ---------------------------------------------------------------------------
`default_nettype none

module fir_chk #(
  parameter int SAMPLE_WIDTH = fir_pkg::SAMPLE_WIDTH_DEF
) (
  input wire logic                           clk,
  input wire logic                           rst,
  input wire logic                           in_valid,
  input wire logic                           in_ready,
  input wire logic                           in_operation,
  input wire logic                           out_valid,
  input wire logic                           out_ready,
  input wire logic signed [SAMPLE_WIDTH-1:0] out_sample,
  input wire logic                           out_saturated,
  input wire logic                           psel,
  input wire logic                           penable,
  input wire logic                           pwrite,
  input wire logic [fir_pkg::PADDR_W-1:0]    paddr,
  input wire logic [fir_pkg::PDATA_W-1:0]    pwdata,
  input wire logic [fir_pkg::PDATA_W-1:0]    prdata
);
  import fir_pkg::*;

  localparam logic signed [SAMPLE_WIDTH-1:0] S_MAX = {1'b0, {(SAMPLE_WIDTH-1){1'b1}}};
  localparam logic signed [SAMPLE_WIDTH-1:0] S_MIN = {1'b1, {(SAMPLE_WIDTH-1){1'b0}}};

  // A result beat stays offered until taken
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid)
    else $error("result beat withdrawn before it was taken");

  // A sample beat starts a multi-cycle walk: no input next cycle
  a_busy: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready && in_operation == OP_SAMPLE |=> !in_ready)
    else $error("input taken while a sample is being worked");

  // Clipped outputs sit at a rail
  a_sat_rail: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_saturated |-> out_sample == S_MAX || out_sample == S_MIN)
    else $error("saturated flag without a rail value");

  // No result straight out of reset
  a_rst_quiet: assert property (@(posedge clk)
    $past(rst) |-> !out_valid)
    else $error("result offered right after reset");

  // Tap count write reads back
  a_cfg_rb: assert property (@(posedge clk) disable iff (rst)
    psel && penable && pwrite && paddr[PADDR_W-1 -: CFG_IDX_W] == REG_TAP_COUNT
    |=> paddr[PADDR_W-1 -: CFG_IDX_W] != REG_TAP_COUNT
        || prdata[TAP_COUNT_W-1:0] == $past(pwdata[TAP_COUNT_W-1:0]))
    else $error("tap count read-back mismatch");

endmodule : fir_chk

bind fir_full_convolution fir_chk #(
  .SAMPLE_WIDTH (SAMPLE_WIDTH)
) u_fir_chk (
  .clk           (clk),
  .rst           (rst),
  .in_valid      (in_ch.valid),
  .in_ready      (in_ch.ready),
  .in_operation  (in_ch.operation),
  .out_valid     (out_ch.valid),
  .out_ready     (out_ch.ready),
  .out_sample    (out_ch.sample),
  .out_saturated (out_ch.saturated),
  .psel          (psel),
  .penable       (penable),
  .pwrite        (pwrite),
  .paddr         (paddr),
  .pwdata        (pwdata),
  .prdata        (prdata)
);

`default_nettype wire
